### design/hes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hes_pkg: shared constants of the Hamiltonian energy stencil
// Field widths, configuration register indexes, reset values and the
// fixed-point shifts that the datapath uses.
// ----------------------------------------------------------------------------
package hes_pkg;

    // Port field widths.
    localparam int FIELD_W  = 16;   // psi_re, psi_im, potential
    localparam int ENERGY_W = 64;   // result energy
    localparam int KCOEF_W  = 24;   // kinetic coefficient, Q8.16
    localparam int CELL_W   = 32;   // cell width, unsigned Q16.16

    // Configuration port.
    localparam int          CFG_IDX_W   = 1;
    localparam int          CFG_DATA_W  = CELL_W;
    localparam logic [0:0]  REG_KINETIC = 1'b0;
    localparam logic [0:0]  REG_CELL    = 1'b1;

    // Reset value of the cell width: 1.0 in Q16.16.
    localparam logic [CELL_W-1:0] CELL_RESET = 32'h0001_0000;

    // Fraction bits of the coefficients, removed after each product.
    localparam int KIN_SHIFT = 16;
    localparam int POT_SHIFT = 8;

    // Fraction bits of the accumulator.
    localparam int ACC_FRAC = 28;

endpackage

### design/hamiltonian_energy_stencil_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamiltonian_energy_stencil_top: streaming energy expectation of a 1-D
// wavefunction under a three-point finite-difference Hamiltonian.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-------------------------------
//   input   | in        | in_valid / in_ready  | psi_re, psi_im, potential, last
//   output  | out       | out_valid / out_ready| energy, saturated
//   config  | in        | cfg_wr_en            | cfg_index, cfg_data
//
// An ordinary sample passes the accepting cycle and eight sequencer steps around
// the one shared multiplier. A first sample that is not the last is only held.
// A last sample runs two evaluations and five scaling steps, or one evaluation
// when it is the only one. Reset is asynchronous and clears the stream state and
// the control and configuration registers. A last sample stalls in the final
// step only while the output register still holds an untaken result.
// ----------------------------------------------------------------------------
module hamiltonian_energy_stencil_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [hes_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hes_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Input channel.
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [hes_pkg::FIELD_W-1:0]  psi_re,
    input  logic signed [hes_pkg::FIELD_W-1:0]  psi_im,
    input  logic signed [hes_pkg::FIELD_W-1:0]  potential,
    input  logic                                last,
    // Output channel.
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [hes_pkg::ENERGY_W-1:0] energy,
    output logic                                saturated
);

    // ------------------------------------------------------------------------
    // Widths
    // ------------------------------------------------------------------------
    localparam int SW   = SAMPLE_BITS;
    localparam int LW   = SW + 2;               // neighbor sum a + c - 2b
    localparam int DW   = 2 * SW + 3;           // kinetic dot product
    localparam int MW   = 2 * SW + 1;           // squared magnitude
    localparam int QW   = 36;                   // products brought to Q.28
    localparam int MA   = (LW > QW) ? LW : QW;  // multiplier operand A
    localparam int MB   = hes_pkg::CELL_W + 1;  // operand B holds cell width
    localparam int PW   = MA + MB;
    localparam int EW   = hes_pkg::ENERGY_W;
    localparam int SCW  = EW + hes_pkg::CELL_W; // full scaling product

    // Conversion of a sample product to Q.28.
    localparam int FRAC = 2 * (SW - 2);
    localparam int SHR  = (FRAC >= hes_pkg::ACC_FRAC) ? FRAC - hes_pkg::ACC_FRAC : 0;
    localparam int SHL  = (FRAC < hes_pkg::ACC_FRAC) ? hes_pkg::ACC_FRAC - FRAC : 0;
    localparam logic signed [63:0] Q28_RND = (SHR == 0) ? 64'sd0 : (64'sd1 <<< (SHR - 1));

    localparam logic signed [PW-1:0] KIN_RND = PW'(1) <<< (hes_pkg::KIN_SHIFT - 1);
    localparam logic signed [PW-1:0] POT_RND = PW'(1) <<< (hes_pkg::POT_SHIFT - 1);
    localparam logic [SCW-1:0] SCALE_RND = SCW'(1) <<< (hes_pkg::KIN_SHIFT - 1);

    localparam logic [EW-1:0] E_MAX = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] E_MIN = {1'b1, {(EW-1){1'b0}}};

    // Sequencer codes.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M1   = 4'd1;   // issue b.re * lap.re
    localparam logic [3:0] S_M2   = 4'd2;   // issue b.im * lap.im
    localparam logic [3:0] S_M3   = 4'd3;   // issue b.re * b.re
    localparam logic [3:0] S_M4   = 4'd4;   // issue b.im * b.im
    localparam logic [3:0] S_M5   = 4'd5;   // issue dot * k
    localparam logic [3:0] S_M6   = 4'd6;   // issue |b|^2 * V
    localparam logic [3:0] S_M7   = 4'd7;   // add potential term
    localparam logic [3:0] S_ACC  = 4'd8;   // saturating accumulate
    localparam logic [3:0] S_SC0  = 4'd9;   // take magnitude of the sum
    localparam logic [3:0] S_SC1  = 4'd10;  // issue low half * cell width
    localparam logic [3:0] S_SC2  = 4'd11;  // issue high half * cell width
    localparam logic [3:0] S_SC3  = 4'd12;  // combine partial products
    localparam logic [3:0] S_SC4  = 4'd13;  // round, saturate, deliver

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic [3:0]                  state_reg, state_next;
    logic signed [hes_pkg::KCOEF_W-1:0] kcoef_reg;
    logic [hes_pkg::CELL_W-1:0]  cell_reg;

    logic signed [SW-1:0]        prev_re_reg, prev_re_next, prev_im_reg, prev_im_next;
    logic signed [SW-1:0]        held_re_reg, held_re_next, held_im_reg, held_im_next;
    logic signed [SW-1:0]        cur_re_reg, cur_re_next, cur_im_reg, cur_im_next;
    logic signed [hes_pkg::FIELD_W-1:0] held_pot_reg, held_pot_next;
    logic signed [hes_pkg::FIELD_W-1:0] cur_pot_reg, cur_pot_next;
    logic                        held_valid_reg, held_valid_next;
    logic                        last_reg, last_next;
    logic                        tail_reg, tail_next;

    logic signed [PW-1:0]        mul_reg, mul_next;
    logic signed [DW-1:0]        dot_reg, dot_next;
    logic signed [MW-1:0]        mag_reg, mag_next;
    logic signed [EW-1:0]        term_reg, term_next;
    logic signed [EW-1:0]        esum_reg, esum_next;
    logic                        ovf_reg, ovf_next;
    logic                        neg_reg, neg_next;
    logic [EW-1:0]               magn_reg, magn_next;
    logic [SCW-1:0]              scl_reg, scl_next;

    logic                        out_valid_reg, out_valid_next;
    logic [EW-1:0]               energy_reg, energy_next;
    logic                        sat_reg, sat_next;

    // ------------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------------
    logic signed [SW-1:0] in_re, in_im, c_re, c_im;
    logic signed [LW-1:0] lap_re, lap_im;
    logic signed [MA-1:0] op_a;
    logic signed [MB-1:0] op_b;
    logic signed [PW-1:0] kin_rnd, pot_rnd;
    logic [EW:0]          acc_sum;
    logic [EW-1:0]        sc_res;
    logic                 sc_hi;
    logic                 in_fire, out_fire, commit;

    // Brings a sample product to Q.28, rounding half up on a right shift.
    function automatic logic signed [63:0] to_q28(input logic signed [63:0] x);
        logic signed [63:0] r;
        r = ((x + Q28_RND) >>> SHR) <<< SHL;
        return r;
    endfunction

    // Only the low SAMPLE_BITS bits of psi_re and psi_im are used.
    assign in_re = signed'(SW'($unsigned(psi_re)));
    assign in_im = signed'(SW'($unsigned(psi_im)));

    // The right neighbor is zero when the held sample closes the vector.
    assign c_re = tail_reg ? '0 : cur_re_reg;
    assign c_im = tail_reg ? '0 : cur_im_reg;

    assign lap_re = LW'(prev_re_reg) + LW'(c_re) - (LW'(held_re_reg) <<< 1);
    assign lap_im = LW'(prev_im_reg) + LW'(c_im) - (LW'(held_im_reg) <<< 1);

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign commit   = (state_reg == S_SC4) && (!out_valid_reg || out_ready);

    // Operand selection of the shared multiplier.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            S_M1:
            begin
                op_a = MA'(lap_re);
                op_b = MB'(held_re_reg);
            end
            S_M2:
            begin
                op_a = MA'(lap_im);
                op_b = MB'(held_im_reg);
            end
            S_M3:
            begin
                op_a = MA'(held_re_reg);
                op_b = MB'(held_re_reg);
            end
            S_M4:
            begin
                op_a = MA'(held_im_reg);
                op_b = MB'(held_im_reg);
            end
            S_M5:
            begin
                op_a = MA'(to_q28(64'(dot_reg)));
                op_b = MB'(kcoef_reg);
            end
            S_M6:
            begin
                op_a = MA'(to_q28(64'(mag_reg)));
                op_b = MB'(held_pot_reg);
            end
            S_SC1:
            begin
                op_a = MA'({1'b0, magn_reg[31:0]});
                op_b = MB'({1'b0, cell_reg});
            end
            S_SC2:
            begin
                op_a = MA'({1'b0, magn_reg[63:32]});
                op_b = MB'({1'b0, cell_reg});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_next = op_a * op_b;

    // Rounded coefficient products, half up.
    assign kin_rnd = (mul_reg + KIN_RND) >>> hes_pkg::KIN_SHIFT;
    assign pot_rnd = (mul_reg + POT_RND) >>> hes_pkg::POT_SHIFT;

    // Accumulator sum with one guard bit for overflow detection.
    assign acc_sum = {esum_reg[EW-1], esum_reg} + {term_reg[EW-1], term_reg};

    // Scaled magnitude and its overflow above 64 bits.
    assign sc_res = scl_reg[EW+15:16];
    assign sc_hi  = |scl_reg[SCW-1:EW+16];

    // ------------------------------------------------------------------------
    // Sequencer and datapath next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        prev_re_next    = prev_re_reg;
        prev_im_next    = prev_im_reg;
        held_re_next    = held_re_reg;
        held_im_next    = held_im_reg;
        cur_re_next     = cur_re_reg;
        cur_im_next     = cur_im_reg;
        held_pot_next   = held_pot_reg;
        cur_pot_next    = cur_pot_reg;
        held_valid_next = held_valid_reg;
        last_next       = last_reg;
        tail_next       = tail_reg;
        dot_next        = dot_reg;
        mag_next        = mag_reg;
        term_next       = term_reg;
        esum_next       = esum_reg;
        ovf_next        = ovf_reg;
        neg_next        = neg_reg;
        magn_next       = magn_reg;
        scl_next        = scl_reg;
        out_valid_next  = out_fire ? 1'b0 : out_valid_reg;
        energy_next     = energy_reg;
        sat_next        = sat_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (held_valid_reg)
                    begin
                        // A held sample now has its right neighbor.
                        cur_re_next  = in_re;
                        cur_im_next  = in_im;
                        cur_pot_next = potential;
                        last_next    = last;
                        tail_next    = 1'b0;
                        state_next   = S_M1;
                    end
                    else
                    begin
                        // First sample of a vector is held; it is evaluated at once only if it is also the last.
                        held_re_next    = in_re;
                        held_im_next    = in_im;
                        held_pot_next   = potential;
                        held_valid_next = 1'b1;
                        tail_next       = last;
                        state_next      = last ? S_M1 : S_IDLE;
                    end
                end
            end
            S_M1:
            begin
                state_next = S_M2;
            end
            S_M2:
            begin
                dot_next   = DW'(mul_reg);
                state_next = S_M3;
            end
            S_M3:
            begin
                dot_next   = dot_reg + DW'(mul_reg);
                state_next = S_M4;
            end
            S_M4:
            begin
                mag_next   = MW'(mul_reg);
                state_next = S_M5;
            end
            S_M5:
            begin
                mag_next   = mag_reg + MW'(mul_reg);
                state_next = S_M6;
            end
            S_M6:
            begin
                term_next  = EW'(kin_rnd);
                state_next = S_M7;
            end
            S_M7:
            begin
                term_next  = term_reg + EW'(pot_rnd);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                // Saturate toward the direction of an overflow.
                if (acc_sum[EW] != acc_sum[EW-1])
                begin
                    esum_next = acc_sum[EW] ? E_MIN : E_MAX;
                    ovf_next  = 1'b1;
                end
                else
                begin
                    esum_next = acc_sum[EW-1:0];
                end
                if (tail_reg)
                begin
                    state_next = S_SC0;
                end
                else
                begin
                    // Shift the window by one sample.
                    prev_re_next  = held_re_reg;
                    prev_im_next  = held_im_reg;
                    held_re_next  = cur_re_reg;
                    held_im_next  = cur_im_reg;
                    held_pot_next = cur_pot_reg;
                    tail_next     = last_reg;
                    state_next    = last_reg ? S_M1 : S_IDLE;
                end
            end
            S_SC0:
            begin
                neg_next   = esum_reg[EW-1];
                magn_next  = esum_reg[EW-1] ? (EW'(0) - esum_reg) : esum_reg;
                state_next = S_SC1;
            end
            S_SC1:
            begin
                state_next = S_SC2;
            end
            S_SC2:
            begin
                scl_next   = SCW'(mul_reg[EW-1:0]);
                state_next = S_SC3;
            end
            S_SC3:
            begin
                scl_next   = scl_reg + {mul_reg[EW-1:0], 32'd0} + SCALE_RND;
                state_next = S_SC4;
            end
            S_SC4:
            begin
                if (commit)
                begin
                    // Round to nearest with ties away from zero, then saturate.
                    if (neg_reg)
                    begin
                        if (sc_hi || (sc_res > E_MIN))
                        begin
                            energy_next = E_MIN;
                            sat_next    = 1'b1;
                        end
                        else
                        begin
                            energy_next = EW'(0) - sc_res;
                            sat_next    = ovf_reg;
                        end
                    end
                    else if (sc_hi || sc_res[EW-1])
                    begin
                        energy_next = E_MAX;
                        sat_next    = 1'b1;
                    end
                    else
                    begin
                        energy_next = sc_res;
                        sat_next    = ovf_reg;
                    end
                    out_valid_next = 1'b1;

                    // Clear the stream state for the next vector.
                    prev_re_next    = '0;
                    prev_im_next    = '0;
                    held_re_next    = '0;
                    held_im_next    = '0;
                    held_pot_next   = '0;
                    held_valid_next = 1'b0;
                    tail_next       = 1'b0;
                    esum_next       = '0;
                    ovf_next        = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Control and stream state registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prev_re_reg    <= '0;
            prev_im_reg    <= '0;
            held_re_reg    <= '0;
            held_im_reg    <= '0;
            held_pot_reg   <= '0;
            held_valid_reg <= 1'b0;
            last_reg       <= 1'b0;
            tail_reg       <= 1'b0;
            esum_reg       <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_re_reg    <= prev_re_next;
            prev_im_reg    <= prev_im_next;
            held_re_reg    <= held_re_next;
            held_im_reg    <= held_im_next;
            held_pot_reg   <= held_pot_next;
            held_valid_reg <= held_valid_next;
            last_reg       <= last_next;
            tail_reg       <= tail_next;
            esum_reg       <= esum_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cur_re_reg  <= cur_re_next;
        cur_im_reg  <= cur_im_next;
        cur_pot_reg <= cur_pot_next;
        mul_reg     <= mul_next;
        dot_reg     <= dot_next;
        mag_reg     <= mag_next;
        term_reg    <= term_next;
        neg_reg     <= neg_next;
        magn_reg    <= magn_next;
        scl_reg     <= scl_next;
        energy_reg  <= energy_next;
        sat_reg     <= sat_next;
    end

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kcoef_reg <= '0;
            cell_reg  <= hes_pkg::CELL_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                hes_pkg::REG_KINETIC: kcoef_reg <= cfg_data[hes_pkg::KCOEF_W-1:0];
                hes_pkg::REG_CELL:    cell_reg  <= cfg_data[hes_pkg::CELL_W-1:0];
                default:              ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------------
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign energy    = energy_reg;
    assign saturated = sat_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A delivered result leaves the stream state cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (!held_valid_reg && (esum_reg == '0) && !ovf_reg))
        else $error("stream state not cleared after a result");

    // A sample that meets a held one starts an evaluation with a live neighbor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && held_valid_reg) |=> ((state_reg == S_M1) && !tail_reg))
        else $error("accepted sample did not start an evaluation");

    // Scaling runs only for the closing evaluation of a vector.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SC0) |-> (tail_reg && held_valid_reg))
        else $error("scaling started outside the end of a vector");

    // The idle sequencer never carries a pending end of vector.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !tail_reg)
        else $error("end-of-vector flag left set in idle");

    // A result is never overwritten before it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !commit)
        else $error("result overwritten while waiting");

endmodule
